>>> sv/fma_pkg.sv
// ----------------------------------------------------------------------------
// fma_pkg - Fock matrix accumulator shared definitions
// Item codes, data widths, control struct and saturation helpers.
// ----------------------------------------------------------------------------
package fma_pkg;

  localparam int DEF_BASIS_SIZE = 16;
  localparam int DEF_FRAC_BITS  = 24;

  localparam int IDX_W  = 4;
  localparam int DATA_W = 32;
  localparam int ACC_W  = 48;
  localparam int PROD_W = 64;
  localparam int SUM_W  = PROD_W + 1;

  // item function codes
  typedef enum logic [1:0] {
    FN_LOAD_D = 2'd0,
    FN_LOAD_H = 2'd1,
    FN_INTEG  = 2'd2,
    FN_READ   = 2'd3
  } func_t;

  // control of the product / rounding unit
  typedef struct packed {
    logic mul_en;   // register value * density
    logic rnd_en;   // register rounded term from held product
    logic exch;     // exchange term: extra halving and negation
  } term_ctl_t;

  // clamp a widened sum to the 48-bit accumulator range
  function automatic logic [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    lo = {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
    if (x > hi) begin
      sat_acc = hi[ACC_W-1:0];
    end else if (x < lo) begin
      sat_acc = lo[ACC_W-1:0];
    end else begin
      sat_acc = x[ACC_W-1:0];
    end
  endfunction

  // true when a 48-bit value lies outside the 32-bit range
  function automatic logic out_of_range(input logic [ACC_W-1:0] x);
    out_of_range = (x[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){1'b0}}) &&
                   (x[ACC_W-1:DATA_W-1] != {(ACC_W-DATA_W+1){1'b1}});
  endfunction

endpackage

>>> sv/fma_in_if.sv
// ----------------------------------------------------------------------------
// fma_in_if - request channel of the Fock matrix accumulator
// Valid/ready handshake carrying one load, integral or read item.
// ----------------------------------------------------------------------------
interface fma_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        func;
  logic [fma_pkg::IDX_W-1:0]         index_p;
  logic [fma_pkg::IDX_W-1:0]         index_q;
  logic [fma_pkg::IDX_W-1:0]         index_r;
  logic [fma_pkg::IDX_W-1:0]         index_s;
  logic signed [fma_pkg::DATA_W-1:0] value;

  modport source (output valid, func, index_p, index_q, index_r, index_s, value,
                  input ready);
  modport sink   (input valid, func, index_p, index_q, index_r, index_s, value,
                  output ready);
endinterface

>>> sv/fma_out_if.sv
// ----------------------------------------------------------------------------
// fma_out_if - response channel of the Fock matrix accumulator
// Valid/ready handshake carrying one saturated Fock element.
// ----------------------------------------------------------------------------
interface fma_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [fma_pkg::DATA_W-1:0] fock_value;
  logic                              saturated;

  modport source (output valid, fock_value, saturated, input ready);
  modport sink   (input valid, fock_value, saturated, output ready);
endinterface

>>> sv/fma_term.sv
// ----------------------------------------------------------------------------
// fma_term - product and rounding unit
// Registers value*density, then the rounded Coulomb or exchange term.
// ----------------------------------------------------------------------------
module fma_term #(
  parameter int FRAC_BITS = fma_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk,
  input  fma_pkg::term_ctl_t                 ctl,
  input  logic signed [fma_pkg::DATA_W-1:0]  value,
  input  logic signed [fma_pkg::DATA_W-1:0]  dens,
  output logic signed [fma_pkg::PROD_W-1:0]  term
);

  localparam logic signed [fma_pkg::PROD_W-1:0] HALF_C =
    fma_pkg::PROD_W'(64'd1) <<< (FRAC_BITS - 1);
  localparam logic signed [fma_pkg::PROD_W-1:0] HALF_X =
    fma_pkg::PROD_W'(64'd1) <<< FRAC_BITS;

  logic signed [fma_pkg::PROD_W-1:0] prod;
  logic signed [fma_pkg::PROD_W-1:0] biased;
  logic signed [fma_pkg::PROD_W-1:0] rnd;
  logic signed [fma_pkg::PROD_W-1:0] term_next;

  // round to nearest, ties up: floor((x + half) / 2^n)
  always_comb begin
    biased = prod + (ctl.exch ? HALF_X : HALF_C);
    rnd    = ctl.exch ? (biased >>> (FRAC_BITS + 1)) : (biased >>> FRAC_BITS);
    term_next = ctl.exch ? -rnd : rnd;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= value * dens;
    end
    if (ctl.rnd_en) begin
      term <= term_next;
    end
  end

endmodule

>>> sv/fock_matrix_accumulator.sv
// ----------------------------------------------------------------------------
// fock_matrix_accumulator - RHF Fock matrix build, F = H + J - 0.5K
// Density and Fock stores in on-chip RAM, updated by read-modify-write.
// ----------------------------------------------------------------------------
// Usage: load D(p,q) items (func 0) and H(p,q) items (func 1, which sets
// F(p,q) = H(p,q)), then stream integrals g(p,q,r,s) (func 2). Each integral
// adds round(g*D(s,r)) to F(p,q) and then -round(g*D(q,r)/2) to F(p,s); each
// update saturates to 48 bits. A read item (func 3) returns F(p,q) clamped to
// 32 bits with a saturation flag. Values are signed fixed point with
// FRAC_BITS fraction bits. A load item is written as it is accepted; a
// read item goes through one RAM read, then the output register; an
// integral goes through S_M1, S_M2, S_A1 and S_A2. That order is set by
// the single read port of each store: the two density reads go one after
// the other, then the Fock entry F(p,q) is read, updated and written, then
// F(p,s), with the multiply and rounding of each term in a registered unit
// in between. One item is in flight at a time; a new item is taken while a
// read result still waits on the output register. Indices at or above
// BASIS_SIZE make load and integral items no-ops and a read returns zero.
// Stores are not cleared at reset: read only what was written.
// ----------------------------------------------------------------------------
module fock_matrix_accumulator #(
  parameter int BASIS_SIZE = fma_pkg::DEF_BASIS_SIZE,
  parameter int FRAC_BITS  = fma_pkg::DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  fma_in_if.sink   req,
  fma_out_if.source rsp
);

  localparam int DEPTH = BASIS_SIZE * BASIS_SIZE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,   // waiting for an item
    S_M1   = 6'b000010,   // g*D(s,r) multiply, D(q,r) read
    S_M2   = 6'b000100,   // Coulomb round, g*D(q,r) multiply, F(p,q) read
    S_A1   = 6'b001000,   // F(p,q) write, exchange round, F(p,s) read
    S_A2   = 6'b010000,   // F(p,s) write
    S_RD   = 6'b100000    // read result to output register
  } state_t;

  state_t state;
  state_t state_next;

  function automatic logic [AW-1:0] ent(input logic [fma_pkg::IDX_W-1:0] a,
                                        input logic [fma_pkg::IDX_W-1:0] b);
    ent = AW'(AW'(a) * AW'(BASIS_SIZE)) + AW'(b);
  endfunction

  function automatic logic idx_ok(input logic [fma_pkg::IDX_W-1:0] a);
    idx_ok = int'(a) < BASIS_SIZE;
  endfunction

  // held item
  logic [fma_pkg::IDX_W-1:0]         ip, iq, ir, is;
  logic signed [fma_pkg::DATA_W-1:0] ival;
  logic                              rd_ok;

  // stores
  logic signed [fma_pkg::DATA_W-1:0] dens_mem [DEPTH];
  logic [fma_pkg::ACC_W-1:0]         fock_mem [DEPTH];

  logic                              dens_we, dens_re;
  logic [AW-1:0]                     dens_waddr, dens_raddr;
  logic signed [fma_pkg::DATA_W-1:0] dens_rd;

  logic                              fock_we, fock_re;
  logic [AW-1:0]                     fock_waddr, fock_raddr;
  logic [fma_pkg::ACC_W-1:0]         fock_wdata, fock_rd;

  // update path
  logic [fma_pkg::ACC_W-1:0]          acc_op;
  logic [fma_pkg::ACC_W-1:0]          upd;
  logic [fma_pkg::ACC_W-1:0]          hold;     // last F(p,q) written, for q == s
  logic signed [fma_pkg::PROD_W-1:0]  term;
  fma_pkg::term_ctl_t                 tctl;

  // output register
  logic                              out_valid;
  logic signed [fma_pkg::DATA_W-1:0] out_value;
  logic                              out_sat;
  logic                              out_load;

  logic        accept;
  logic        in_pq_ok, in_all_ok;
  logic [1:0]  in_func;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign in_func   = req.func;
  assign in_pq_ok  = idx_ok(req.index_p) && idx_ok(req.index_q);
  assign in_all_ok = in_pq_ok && idx_ok(req.index_r) && idx_ok(req.index_s);

  assign out_load = (state == S_RD) && (!out_valid || rsp.ready);

  // second update reads the entry just written when q == s
  assign acc_op = ((state == S_A2) && (iq == is)) ? hold : fock_rd;
  assign upd    = fma_pkg::sat_acc({{(fma_pkg::SUM_W-fma_pkg::ACC_W){acc_op[fma_pkg::ACC_W-1]}},
                                    acc_op} + {term[fma_pkg::PROD_W-1], term});

  // sequencer and memory port control
  always_comb begin
    state_next = state;
    dens_we    = 1'b0;
    dens_waddr = ent(req.index_p, req.index_q);
    dens_re    = 1'b0;
    dens_raddr = ent(is, ir);
    fock_we    = 1'b0;
    fock_waddr = ent(ip, iq);
    fock_wdata = upd;
    fock_re    = 1'b0;
    fock_raddr = ent(ip, iq);
    tctl       = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_func)
            fma_pkg::FN_LOAD_D: begin
              dens_we = in_pq_ok;
            end
            fma_pkg::FN_LOAD_H: begin
              fock_we    = in_pq_ok;
              fock_waddr = ent(req.index_p, req.index_q);
              fock_wdata = {{(fma_pkg::ACC_W-fma_pkg::DATA_W){req.value[fma_pkg::DATA_W-1]}},
                            req.value};
            end
            fma_pkg::FN_INTEG: begin
              dens_re    = in_all_ok;
              dens_raddr = ent(req.index_s, req.index_r);
              if (in_all_ok) begin
                state_next = S_M1;
              end
            end
            fma_pkg::FN_READ: begin
              fock_re    = in_pq_ok;
              fock_raddr = ent(req.index_p, req.index_q);
              state_next = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_M1: begin
        tctl.mul_en = 1'b1;
        dens_re     = 1'b1;
        dens_raddr  = ent(iq, ir);
        state_next  = S_M2;
      end
      S_M2: begin
        tctl.mul_en = 1'b1;
        tctl.rnd_en = 1'b1;
        fock_re     = 1'b1;
        fock_raddr  = ent(ip, iq);
        state_next  = S_A1;
      end
      S_A1: begin
        tctl.rnd_en = 1'b1;
        tctl.exch   = 1'b1;
        fock_we     = 1'b1;
        fock_waddr  = ent(ip, iq);
        fock_re     = 1'b1;
        fock_raddr  = ent(ip, is);
        state_next  = S_A2;
      end
      S_A2: begin
        fock_we    = 1'b1;
        fock_waddr = ent(ip, is);
        state_next = S_IDLE;
      end
      S_RD: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      ip    <= req.index_p;
      iq    <= req.index_q;
      ir    <= req.index_r;
      is    <= req.index_s;
      ival  <= req.value;
      rd_ok <= in_pq_ok;
    end
    if (state == S_A1) begin
      hold <= upd;
    end
  end

  // density store: one write, one registered read
  always_ff @(posedge clk) begin
    if (dens_we) begin
      dens_mem[dens_waddr] <= req.value;
    end
    if (dens_re) begin
      dens_rd <= dens_mem[dens_raddr];
    end
  end

  // Fock store: one write, one registered read (old data on a collision)
  always_ff @(posedge clk) begin
    if (fock_we) begin
      fock_mem[fock_waddr] <= fock_wdata;
    end
    if (fock_re) begin
      fock_rd <= fock_mem[fock_raddr];
    end
  end

  fma_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk   (clk),
    .ctl   (tctl),
    .value (ival),
    .dens  (dens_rd),
    .term  (term)
  );

  // output register, clamp to 32 bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (!rd_ok) begin
        out_value <= '0;
        out_sat   <= 1'b0;
      end else if (fma_pkg::out_of_range(fock_rd)) begin
        out_sat   <= 1'b1;
        out_value <= fock_rd[fma_pkg::ACC_W-1] ?
                     {1'b1, {(fma_pkg::DATA_W-1){1'b0}}} :
                     {1'b0, {(fma_pkg::DATA_W-1){1'b1}}};
      end else begin
        out_sat   <= 1'b0;
        out_value <= fock_rd[fma_pkg::DATA_W-1:0];
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.fock_value = out_value;
  assign rsp.saturated  = out_sat;

  // a result only appears after a read has gone through the read state
  a_out_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_RD)
    else $error("result raised outside the read state");

  // the second Fock update always follows the first
  a_a1_then_a2: assert property (@(posedge clk) disable iff (rst)
    (state == S_A1) |=> (state == S_A2))
    else $error("exchange update skipped");

  // only one store written in a cycle, and the Fock store not while products form
  a_write_slots: assert property (@(posedge clk) disable iff (rst)
    fock_we |-> (!dens_we && state != S_M1 && state != S_M2))
    else $error("Fock write in a multiply step");

endmodule
